FILE: rtl/nearest_center_assignment_assert.svh
// assertion macros shared by the checker of nearest_center_assignment
`ifndef NEAREST_CENTER_ASSIGNMENT_ASSERT_SVH
`define NEAREST_CENTER_ASSIGNMENT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NCA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_center_assignment: property failed");

// next-cycle implication, sampled on clk, off during reset
`define NCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_center_assignment: property failed");

`endif

FILE: rtl/nca_pkg.sv
// shared constants and control types for the nearest center assignment block
`default_nettype none

package nca_pkg;

    // table geometry
    localparam int MAX_CENTERS = 16;
    localparam int MAX_DIMS    = 16;
    localparam int TABLE_DEPTH = MAX_CENTERS * MAX_DIMS;

    // derived widths
    localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // fixed field widths
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 5;
    localparam int LABEL_W = 4;
    localparam int SUM_W   = 40;
    localparam int DIFF_W  = VAL_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;

    // request codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic write;     // store a center element
        logic capture;   // latch a sample element, restart center count
        logic issue;     // start one center through the distance pipeline
        logic load_out;  // move the winner to the output, clear the sums
    } nca_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic k_last;     // center being issued is the last active one
        logic pipe_busy;  // distance pipeline holds work
        logic item_last;  // captured sample element closes the sample
        logic out_full;   // output register holds an untaken result
    } nca_status_t;

endpackage

`default_nettype wire

FILE: rtl/nca_ctrl.sv
// controller state machine for the nearest center assignment block
`default_nettype none

module nca_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 command,
    input  wire logic                 out_ready,
    input  wire nca_pkg::nca_status_t status,
    output logic                      in_ready,
    output nca_pkg::nca_cmd_t         cmd
);
    import nca_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } nca_state_t;

    nca_state_t state_reg;
    nca_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.write    = 1'b0;
        cmd.capture  = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_SAMPLE)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SWEEP;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (status.k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = status.item_last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nca_datapath.sv
// center table, shared squaring pipeline, distance sums and output register
`default_nettype none

module nca_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire nca_pkg::nca_cmd_t          cmd,
    output nca_pkg::nca_status_t            status,
    input  wire logic                       cfg_write_en,
    input  wire logic [nca_pkg::CFG_W-1:0]  cfg_write_data,
    input  wire logic [nca_pkg::IDX_W-1:0]  center_index,
    input  wire logic [nca_pkg::IDX_W-1:0]  dim_index,
    input  wire logic signed [nca_pkg::VAL_W-1:0] element_value,
    input  wire logic                       last_element,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [nca_pkg::LABEL_W-1:0]     nearest_label,
    output logic [nca_pkg::SUM_W-1:0]       min_distance
);
    import nca_pkg::*;

    // configuration
    logic [CFG_W-1:0]  active_reg;
    logic [CIDX_W-1:0] k_max;

    // captured sample element
    logic signed [VAL_W-1:0] item_value_reg;
    logic [IDX_W-1:0]        item_didx_reg;
    logic                    item_didx_ok_reg;
    logic                    item_last_reg;

    // center memory
    logic [VAL_W-1:0]  center_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_ok;

    // pipeline
    logic [CIDX_W-1:0] k_reg;
    logic              s1_valid_reg;
    logic [CIDX_W-1:0] s1_k_reg;
    logic              s2_valid_reg;
    logic [CIDX_W-1:0] s2_k_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              s3_valid_reg;
    logic [CIDX_W-1:0] s3_k_reg;
    logic [SUM_W-1:0]  sum3_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [SQ_W-1:0]   sq_full;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;

    // distance sums and running minimum
    logic [SUM_W-1:0]  sums_reg [MAX_CENTERS];
    logic [SUM_W-1:0]  best_reg;
    logic [CIDX_W-1:0] best_k_reg;

    // output register
    logic              out_valid_reg;
    logic [CIDX_W-1:0] out_label_reg;
    logic [SUM_W-1:0]  out_dist_reg;

    // active count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CFG_W'(1);
        end
        else if (cfg_write_en)
        begin
            active_reg <= cfg_write_data;
        end
    end

    // last center index: zero acts as one, large values clamp to the table
    always_comb
    begin
        if (active_reg == '0)
        begin
            k_max = '0;
        end
        else if (32'(active_reg) > MAX_CENTERS)
        begin
            k_max = CIDX_W'(MAX_CENTERS - 1);
        end
        else
        begin
            k_max = CIDX_W'(active_reg - CFG_W'(1));
        end
    end

    // sample element capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_value_reg   <= element_value;
            item_didx_reg    <= dim_index;
            item_didx_ok_reg <= (32'(dim_index) < MAX_DIMS);
            item_last_reg    <= last_element;
        end
    end

    // center memory write and read
    assign wr_ok   = (32'(center_index) < MAX_CENTERS) && (32'(dim_index) < MAX_DIMS);
    assign wr_addr = ADDR_W'(32'(center_index) * MAX_DIMS + 32'(dim_index));
    assign rd_addr = ADDR_W'(32'(k_reg) * MAX_DIMS + 32'(item_didx_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            center_mem[wr_addr] <= element_value;
        end
        if (cmd.issue && item_didx_ok_reg)
        begin
            rd_data_reg <= center_mem[rd_addr];
        end
    end

    // center counter and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                k_reg <= '0;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + CIDX_W'(1);
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: difference and square, zero for a dimension off the table
    assign diff    = DIFF_W'(item_value_reg) - DIFF_W'($signed(rd_data_reg));
    assign sq_full = diff * diff;

    always_ff @(posedge clk)
    begin
        s1_k_reg <= k_reg;
        s2_k_reg <= s1_k_reg;
        s3_k_reg <= s2_k_reg;
        sq_reg   <= item_didx_ok_reg ? SQ_W'($unsigned(sq_full)) : '0;
    end

    // stage 2: saturating accumulate
    assign sum_wide = {1'b0, sums_reg[s2_k_reg]} + (SUM_W + 1)'(sq_reg);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CENTERS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (cmd.load_out)
        begin
            for (int i = 0; i < MAX_CENTERS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (s2_valid_reg)
        begin
            sums_reg[s2_k_reg] <= sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            sum3_reg <= sum_sat;
        end
    end

    // stage 3: running minimum, strictly smaller wins
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && ((s3_k_reg == '0) || (sum3_reg < best_reg)))
        begin
            best_reg   <= sum3_reg;
            best_k_reg <= s3_k_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_label_reg <= best_k_reg;
            out_dist_reg  <= best_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign nearest_label = LABEL_W'(out_label_reg);
    assign min_distance  = out_dist_reg;

    // status to the controller
    assign status.k_last    = (k_reg == k_max);
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.item_last = item_last_reg;
    assign status.out_full  = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/nearest_center_assignment.sv
// top level of the k-means nearest center assignment block
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------------------
//  input     in_valid / in_ready    command, center_index, dim_index, element_value,
//                                   last_element
//  output    out_valid / out_ready  nearest_label, min_distance
//  config    cfg_write_en           cfg_write_data (active_centers)
//
// a center load request is written to the table as it is accepted; a sample request
// sweeps the N active centers, one center per cycle, a rate set by the one shared
// squaring unit and the single read port of the center table, then waits for the
// 3-stage pipeline to drain and for the controller to see it empty.
// a request marked last then moves the result into the output register, waiting
// while an earlier result is still untaken.
// reset clears control, the distance sums and active_centers (to 1); the center
// table holds no reset value and needs no clearing pass.
`default_nettype none

module nearest_center_assignment (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic [nca_pkg::IDX_W-1:0]        center_index,
    input  wire logic [nca_pkg::IDX_W-1:0]        dim_index,
    input  wire logic signed [nca_pkg::VAL_W-1:0] element_value,
    input  wire logic                             last_element,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [nca_pkg::LABEL_W-1:0]           nearest_label,
    output logic [nca_pkg::SUM_W-1:0]             min_distance,
    input  wire logic                             cfg_write_en,
    input  wire logic [nca_pkg::CFG_W-1:0]        cfg_write_data
);
    import nca_pkg::*;

    nca_cmd_t    cmd;
    nca_status_t status;

    // sequencing
    nca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // storage and arithmetic
    nca_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .center_index   (center_index),
        .dim_index      (dim_index),
        .element_value  (element_value),
        .last_element   (last_element),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .nearest_label  (nearest_label),
        .min_distance   (min_distance)
    );

endmodule

`default_nettype wire

FILE: rtl/nca_checker.sv
// port-level checker for nearest_center_assignment and its bind
`default_nettype none

`include "nearest_center_assignment_assert.svh"

module nca_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic command,
    input wire logic out_valid,
    input wire logic out_ready
);
    import nca_pkg::*;

    // a result waiting for the consumer is not withdrawn
    `NCA_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)

    // a sample request always takes the block out of idle, so in_ready drops once it is taken
    `NCA_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (command == CMD_SAMPLE), !in_ready)

    // a center load finishes in the cycle it is taken
    `NCA_ASSERT_NEXT(a_load_quick, in_valid && in_ready && (command == CMD_LOAD), in_ready)

    // a new result only appears after the block was busy with a sample
    `NCA_ASSERT_SAME(a_result_after_work, $rose(out_valid), !$past(in_ready))

endmodule

bind nearest_center_assignment nca_checker u_nca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

`default_nettype wire
